/* rtl/core/ssp_pkg.sv */
// Shared types, constants and helpers for the skid-steer pose step pipeline.
// No dependencies; imported by ssp_sin and skid_steer_pose_step.
`timescale 1ns / 1ps

package ssp_pkg;

    // Pipeline depth, input register to output register
    localparam int STAGES = 20;

    // Configuration register indexes
    localparam logic [1:0] REG_STEP_TIME  = 2'd0;
    localparam logic [1:0] REG_ICR_OFFSET = 2'd1;

    // Reset values of the configuration registers
    localparam logic [15:0] STEP_TIME_RST  = 16'd6554;
    localparam logic [31:0] ICR_OFFSET_RST = 32'd0;

    // Turns per radian, unsigned 0.32 scaled
    localparam logic [29:0] TURN_PER_RAD = 30'd683565276;

    // Quarter-wave sine polynomial, Q30
    localparam logic [31:0] SIN_C9  = 32'd172272;
    localparam logic [30:0] Q30_ONE = 31'd1073741824;

    // Constants added after each Horner multiply (C7, C5, C3, C1 with signs)
    localparam logic signed [33:0] SIN_ADD [0:3] = '{
        -34'sd5026995, 34'sd85569306, -34'sd693598668, 34'sd1686629713
    };

    typedef logic signed [31:0] q16_t;

    // Clamp a wide signed value to the signed 32-bit range
    function automatic q16_t sat32(input logic signed [63:0] v);
        q16_t res;
        if (v > 64'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

/* rtl/core/ssp_sin.sv */
// Pipelined quarter-wave sine of a phase word, stages two to thirteen.
// Depends on ssp_pkg; instantiated twice by skid_steer_pose_step.
`timescale 1ns / 1ps

module ssp_sin
    import ssp_pkg::*;
(
    input  logic        aclk,
    input  logic [11:0] en,      // load enable per stage, bit 0 is stage two
    input  logic [31:0] phase,   // unsigned fraction of a turn
    output logic [30:0] s_mag,   // magnitude, Q30, at most one
    output logic        s_neg
);

    logic [30:0] x_reg    [0:9];
    logic [1:0]  quad_reg [0:10];
    logic [30:0] x2_reg   [0:6];
    logic [61:0] pxx_reg;
    logic [62:0] prod_reg [0:3];
    logic        pn_reg   [0:3];
    logic [31:0] tm_reg   [0:3];
    logic        tn_reg   [0:3];
    logic [62:0] ps_reg;
    logic        psn_reg;
    logic [30:0] s_mag_reg;
    logic        s_neg_reg;

    logic [30:0] x_fold;
    logic [62:0] r_full   [0:3];
    logic signed [33:0] t_next [0:3];
    logic [31:0] tm_next  [0:3];
    logic [62:0] rs_full;
    logic [30:0] s_next;

    // Fold the phase onto a quarter wave
    always_comb begin
        x_fold = phase[30] ? (Q30_ONE - {1'b0, phase[29:0]}) : {1'b0, phase[29:0]};
    end

    // Round each Horner product, apply its sign and add the next coefficient
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            r_full[k] = (prod_reg[k] + (63'd1 << 29)) >> 30;
            if (pn_reg[k]) begin
                t_next[k] = SIN_ADD[k] - $signed({1'b0, r_full[k][32:0]});
            end else begin
                t_next[k] = SIN_ADD[k] + $signed({1'b0, r_full[k][32:0]});
            end
            tm_next[k] = t_next[k][33] ? 32'(-t_next[k]) : t_next[k][31:0];
        end
    end

    // Final product: round and clamp to [0, one]
    always_comb begin
        rs_full = (ps_reg + (63'd1 << 29)) >> 30;
        if (psn_reg) begin
            s_next = '0;
        end else if (rs_full > 63'(Q30_ONE)) begin
            s_next = Q30_ONE;
        end else begin
            s_next = rs_full[30:0];
        end
    end

    always_ff @(posedge aclk) begin
        // stage two: fold and square
        if (en[0]) begin
            x_reg[0]    <= x_fold;
            quad_reg[0] <= phase[31:30];
            pxx_reg     <= x_fold * x_fold;
        end
        // stage three: round the square
        if (en[1]) begin
            x2_reg[0] <= 31'((pxx_reg + (62'd1 << 29)) >> 30);
        end
        // carry the fold and the square along the line
        for (int j = 1; j <= 9; j++) begin
            if (en[j]) x_reg[j] <= x_reg[j-1];
        end
        for (int j = 1; j <= 10; j++) begin
            if (en[j]) quad_reg[j] <= quad_reg[j-1];
        end
        for (int j = 1; j <= 6; j++) begin
            if (en[j+1]) x2_reg[j] <= x2_reg[j-1];
        end
        // Horner multiply stages four, six, eight and ten
        if (en[2]) begin
            prod_reg[0] <= x2_reg[0] * SIN_C9;
            pn_reg[0]   <= 1'b0;
        end
        for (int k = 1; k < 4; k++) begin
            if (en[2+2*k]) begin
                prod_reg[k] <= x2_reg[2*k] * tm_reg[k-1];
                pn_reg[k]   <= tn_reg[k-1];
            end
        end
        for (int k = 0; k < 4; k++) begin
            if (en[3+2*k]) begin
                tm_reg[k] <= tm_next[k];
                tn_reg[k] <= t_next[k][33];
            end
        end
        // stage twelve: multiply by the folded phase
        if (en[10]) begin
            ps_reg  <= x_reg[9] * tm_reg[3];
            psn_reg <= tn_reg[3];
        end
        // stage thirteen: round, clamp and take the half-turn sign
        if (en[11]) begin
            s_mag_reg <= s_next;
            s_neg_reg <= quad_reg[10][1];
        end
    end

    assign s_mag = s_mag_reg;
    assign s_neg = s_neg_reg;

endmodule

/* rtl/core/skid_steer_pose_step.sv */
// An accepted transaction moves through all 20 stages to m_tdata; each stage is
// one multiplier bank or one wide add. One transaction per cycle is taken unless
// m_tready is low, all stages full; a stage refills when its successor moves on.
// Reset (aresetn low, synchronous) clears every stage valid bit and loads
// step_time with 6554 and icr_offset with 0.
// Depends on ssp_pkg and ssp_sin.
`timescale 1ns / 1ps

module skid_steer_pose_step
    import ssp_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    // configuration write port
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_wdata,
    // input stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // start_x, start_y, start_heading, lin_vel, turn_rate (32 bits each)
    input  logic [159:0] s_tdata,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // next_x, next_y, next_heading (32 bits each)
    output logic [95:0]  m_tdata
);

    logic [15:0] step_time_reg;
    logic [31:0] icr_offset_reg;

    logic [STAGES:1] valid_reg;
    logic [STAGES:1] en;
    logic [STAGES:1] vbar;

    // carried fields
    logic [31:0] px_c [1:19];
    logic [31:0] py_c [1:19];
    logic [31:0] hd_c [1:3];
    logic [31:0] h_c  [4:19];
    logic [31:0] vmag_c [2:13];
    logic        vneg_c [2:13];
    logic [62:0] wimag_c [2:13];
    logic        wineg_c [2:13];

    // stage registers
    logic [31:0] ph_reg;
    logic [31:0] v_reg;
    logic signed [63:0] wi_reg;
    logic [31:0] wabs_reg;
    logic        wneg_reg;
    logic [47:0] dhp_reg;
    logic        dhn_reg;
    logic signed [33:0] dh_reg;
    logic [62:0] pa_reg, pc_reg, pbl_reg, pdl_reg;
    logic [61:0] pbh_reg, pdh_reg;
    logic        na_reg, nb_reg, nc_reg, nd_reg;
    logic signed [63:0] sa_reg, sb_reg, sc_reg, sd_reg;
    logic signed [63:0] rx_reg, ry_reg;
    logic [62:0] rxm_reg, rym_reg;
    logic        rxn_reg, ryn_reg;
    logic [46:0] pxh_reg, pyh_reg;
    logic [47:0] pxl_reg, pyl_reg;
    logic        rxn2_reg, ryn2_reg;
    logic signed [49:0] dx_reg, dy_reg;
    logic [31:0] nx_reg, ny_reg, nh_reg;

    // combinational pieces
    logic signed [62:0] ph_prod;
    logic signed [63:0] wi_prod;
    logic [31:0] sn_phase, cs_phase;
    logic [30:0] sn_mag, cs_mag;
    logic        sn_neg, cs_neg;
    logic [63:0] ta, tb, tc, td;
    logic [48:0] dhr;
    logic [47:0] mx, my;

    // Write configuration registers; ignore unknown indexes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_time_reg  <= STEP_TIME_RST;
            icr_offset_reg <= ICR_OFFSET_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_STEP_TIME:  step_time_reg  <= cfg_wdata[15:0];
                REG_ICR_OFFSET: icr_offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // A stage loads when the sink takes data or it or any later stage holds a bubble
    always_comb begin
        vbar = ~valid_reg;
        for (int i = 1; i <= STAGES; i++) begin
            en[i] = m_tready || (|(vbar >> (i - 1)));
        end
    end

    assign s_tready = en[1];
    assign m_tvalid = valid_reg[STAGES];
    assign m_tdata  = {nh_reg, ny_reg, nx_reg};

    // Advance valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[1]) valid_reg[1] <= s_tvalid;
            for (int i = 2; i <= STAGES; i++) begin
                if (en[i]) valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // Stage one products: heading to phase, yaw rate times offset
    assign ph_prod = $signed(s_tdata[95:64]) * $signed({1'b0, TURN_PER_RAD});
    assign wi_prod = $signed(s_tdata[159:128]) * $signed(icr_offset_reg);

    // Sine and cosine; the cosine phase is a quarter turn ahead
    assign sn_phase = ph_reg;
    assign cs_phase = {ph_reg[31:30] + 2'd1, ph_reg[29:0]};

    ssp_sin u_sin (
        .aclk  (aclk),
        .en    (en[13:2]),
        .phase (sn_phase),
        .s_mag (sn_mag),
        .s_neg (sn_neg)
    );

    ssp_sin u_cos (
        .aclk  (aclk),
        .en    (en[13:2]),
        .phase (cs_phase),
        .s_mag (cs_mag),
        .s_neg (cs_neg)
    );

    // Rounded velocity terms and heading step
    always_comb begin
        dhr = (49'(dhp_reg) + (49'd1 << 15)) >> 16;
        ta = 64'((pa_reg + (63'd1 << 13)) >> 14);
        tc = 64'((pc_reg + (63'd1 << 13)) >> 14);
        tb = (64'(pbh_reg) << 2) + 64'((pbl_reg + (63'd1 << 29)) >> 30);
        td = (64'(pdh_reg) << 2) + 64'((pdl_reg + (63'd1 << 29)) >> 30);
        mx = 48'(pxh_reg) + 48'((49'(pxl_reg) + (49'd1 << 31)) >> 32);
        my = 48'(pyh_reg) + 48'((49'(pyl_reg) + (49'd1 << 31)) >> 32);
    end

    always_ff @(posedge aclk) begin
        // stage one: capture and first products
        if (en[1]) begin
            px_c[1]  <= s_tdata[31:0];
            py_c[1]  <= s_tdata[63:32];
            hd_c[1]  <= s_tdata[95:64];
            v_reg    <= s_tdata[127:96];
            ph_reg   <= ph_prod[47:16];
            wi_reg   <= wi_prod;
            wabs_reg <= s_tdata[159] ? (~s_tdata[159:128] + 32'd1) : s_tdata[159:128];
            wneg_reg <= s_tdata[159];
        end
        // stage two: magnitudes, heading step product
        if (en[2]) begin
            vmag_c[2]  <= v_reg[31] ? (~v_reg + 32'd1) : v_reg;
            vneg_c[2]  <= v_reg[31];
            wimag_c[2] <= wi_reg[63] ? 63'(~wi_reg + 64'd1) : wi_reg[62:0];
            wineg_c[2] <= wi_reg[63];
            dhp_reg    <= wabs_reg * step_time_reg;
            dhn_reg    <= wneg_reg;
        end
        // stage three: round the heading step
        if (en[3]) begin
            dh_reg <= dhn_reg ? -$signed({1'b0, dhr[32:0]}) : $signed({1'b0, dhr[32:0]});
        end
        // stage four: new heading
        if (en[4]) begin
            h_c[4] <= sat32(64'(signed'(hd_c[3])) + 64'(dh_reg));
        end
        // carry fields along the line
        for (int i = 2; i <= 19; i++) begin
            if (en[i]) begin
                px_c[i] <= px_c[i-1];
                py_c[i] <= py_c[i-1];
            end
        end
        for (int i = 2; i <= 3; i++) begin
            if (en[i]) hd_c[i] <= hd_c[i-1];
        end
        for (int i = 5; i <= 19; i++) begin
            if (en[i]) h_c[i] <= h_c[i-1];
        end
        for (int i = 3; i <= 13; i++) begin
            if (en[i]) begin
                vmag_c[i]  <= vmag_c[i-1];
                vneg_c[i]  <= vneg_c[i-1];
                wimag_c[i] <= wimag_c[i-1];
                wineg_c[i] <= wineg_c[i-1];
            end
        end
        // stage fourteen: velocity times sine and cosine
        if (en[14]) begin
            pa_reg  <= vmag_c[13] * cs_mag;
            pc_reg  <= vmag_c[13] * sn_mag;
            pbh_reg <= wimag_c[13][62:32] * sn_mag;
            pbl_reg <= wimag_c[13][31:0] * sn_mag;
            pdh_reg <= wimag_c[13][62:32] * cs_mag;
            pdl_reg <= wimag_c[13][31:0] * cs_mag;
            na_reg  <= vneg_c[13] ^ cs_neg;
            nc_reg  <= vneg_c[13] ^ sn_neg;
            nb_reg  <= wineg_c[13] ^ sn_neg;
            nd_reg  <= wineg_c[13] ^ cs_neg;
        end
        // stage fifteen: round and sign the four terms
        if (en[15]) begin
            sa_reg <= na_reg ? -$signed(ta) : $signed(ta);
            sb_reg <= nb_reg ? -$signed(tb) : $signed(tb);
            sc_reg <= nc_reg ? -$signed(tc) : $signed(tc);
            sd_reg <= nd_reg ? -$signed(td) : $signed(td);
        end
        // stage sixteen: rotated velocity
        if (en[16]) begin
            rx_reg <= sa_reg + sb_reg;
            ry_reg <= sc_reg - sd_reg;
        end
        // stage seventeen: magnitudes
        if (en[17]) begin
            rxm_reg <= rx_reg[63] ? 63'(-rx_reg) : rx_reg[62:0];
            rym_reg <= ry_reg[63] ? 63'(-ry_reg) : ry_reg[62:0];
            rxn_reg <= rx_reg[63];
            ryn_reg <= ry_reg[63];
        end
        // stage eighteen: scale by the step in two partial products
        if (en[18]) begin
            pxh_reg  <= rxm_reg[62:32] * step_time_reg;
            pxl_reg  <= rxm_reg[31:0] * step_time_reg;
            pyh_reg  <= rym_reg[62:32] * step_time_reg;
            pyl_reg  <= rym_reg[31:0] * step_time_reg;
            rxn2_reg <= rxn_reg;
            ryn2_reg <= ryn_reg;
        end
        // stage nineteen: round the displacement
        if (en[19]) begin
            dx_reg <= rxn2_reg ? -$signed({2'b00, mx}) : $signed({2'b00, mx});
            dy_reg <= ryn2_reg ? -$signed({2'b00, my}) : $signed({2'b00, my});
        end
        // stage twenty: new position, saturated
        if (en[20]) begin
            nx_reg <= sat32(64'(signed'(px_c[19])) + 64'(dx_reg));
            ny_reg <= sat32(64'(signed'(py_c[19])) + 64'(dy_reg));
            nh_reg <= h_c[19];
        end
    end

endmodule

/* rtl/core/ssp_checker.sv */
// Port-level checks for skid_steer_pose_step, bound to the top level.
// Depends on skid_steer_pose_step ports only.
`timescale 1ns / 1ps

module ssp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [95:0] m_tdata
);

    // Hold a stalled result transaction
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Drop all results on reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A sink that takes data never stalls the source
    a_ready_flow: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tready |-> s_tready)
        else $error("input stalled while output drains");

    // An empty output stage always admits a transaction
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

endmodule

bind skid_steer_pose_step ssp_checker u_ssp_checker (.*);
